// ===== src/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the LRU page replacement block
// Field widths of the stream words, parameter defaults and the control
// structs that pass between the sequencer, the scan unit and the rank table.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Parameter defaults.
    localparam int FRAME_COUNT_DEF = 8;
    localparam int PAGE_BITS_DEF   = 16;

    // Fixed field widths of the stream words.
    localparam int CFG_W       = 4;
    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_OUT_W = 3;
    localparam int EVICT_W     = 16;
    localparam int TOTAL_W     = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 56;
    localparam int M_TUSER_W   = 2;

    // Reset value of the frames_in_use register.
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Result of one scan over the active frames.
    typedef struct packed {
        logic hit;          // a resident frame holds the page
        logic empty_found;  // an empty active frame exists
    } scan_flags_t;

    // Recency update request to the rank table.
    typedef struct packed {
        logic en;           // touch the selected frame this cycle
        logic fill;         // the frame is newly filled and becomes valid
    } touch_ctl_t;

endpackage

// ===== src/lpr_ram.sv =====
// ----------------------------------------------------------------------------
// lpr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== src/lpr_scan_unit.sv =====
// ----------------------------------------------------------------------------
// lpr_scan_unit: shared compare unit of the frame scan
// Looks at one frame per cycle and keeps the first hit, the first empty
// frame and the frame with the largest recency rank seen so far.
// ----------------------------------------------------------------------------
module lpr_scan_unit
    import lpr_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    localparam int FIDX_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
    localparam int RANK_W     = $clog2(FRAME_COUNT + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 cmp_en,
    input  logic [FIDX_W-1:0]    cmp_idx,
    input  logic [PAGE_BITS-1:0] key,
    input  logic [PAGE_BITS-1:0] frame_page,
    input  logic                 frame_valid,
    input  logic [RANK_W-1:0]    frame_rank,
    output scan_flags_t          flags,
    output logic [FIDX_W-1:0]    hit_idx,
    output logic [FIDX_W-1:0]    empty_idx,
    output logic [FIDX_W-1:0]    vic_idx,
    output logic [PAGE_BITS-1:0] vic_page
);

    logic                 hit_found_reg;
    logic                 empty_found_reg;
    logic [FIDX_W-1:0]    hit_idx_reg;
    logic [FIDX_W-1:0]    empty_idx_reg;
    logic [FIDX_W-1:0]    vic_idx_reg;
    logic [RANK_W-1:0]    vic_rank_reg;
    logic [PAGE_BITS-1:0] vic_page_reg;

    logic take_hit;
    logic take_empty;
    logic take_vic;

    assign take_hit   = cmp_en && !hit_found_reg && frame_valid && (frame_page == key);
    assign take_empty = cmp_en && !empty_found_reg && !frame_valid;
    // The first frame seeds the oldest-frame search; later frames win only
    // with a strictly larger rank, so ties stay with the lower frame.
    assign take_vic   = cmp_en && ((cmp_idx == '0) || (frame_rank > vic_rank_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end else begin
            if (take_hit) begin
                hit_found_reg <= 1'b1;
            end
            if (take_empty) begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_idx_reg <= cmp_idx;
        end
        if (take_empty) begin
            empty_idx_reg <= cmp_idx;
        end
        if (take_vic) begin
            vic_idx_reg  <= cmp_idx;
            vic_rank_reg <= frame_rank;
            vic_page_reg <= frame_page;
        end
    end

    assign flags.hit         = hit_found_reg;
    assign flags.empty_found = empty_found_reg;
    assign hit_idx           = hit_idx_reg;
    assign empty_idx         = empty_idx_reg;
    assign vic_idx           = vic_idx_reg;
    assign vic_page          = vic_page_reg;

endmodule

// ===== src/lpr_rank_table.sv =====
// ----------------------------------------------------------------------------
// lpr_rank_table: frame valid bits and exact recency ranks
// Rank 0 marks a frame never touched, rank 1 the most recently used one.
// A touch moves one frame to rank 1 and ages every younger frame by one.
// ----------------------------------------------------------------------------
module lpr_rank_table
    import lpr_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    localparam int FIDX_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
    localparam int RANK_W     = $clog2(FRAME_COUNT + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  touch_ctl_t             touch,
    input  logic [FIDX_W-1:0]      touch_idx,
    input  logic [FIDX_W-1:0]      rd_idx,
    output logic [FRAME_COUNT-1:0] valid_vec,
    output logic [RANK_W-1:0]      rd_rank
);

    logic [FRAME_COUNT-1:0] valid_reg;
    logic [FRAME_COUNT-1:0] valid_next;
    logic [RANK_W-1:0]      rank_reg  [FRAME_COUNT];
    logic [RANK_W-1:0]      rank_next [FRAME_COUNT];

    always_comb begin
        logic [RANK_W-1:0] old_rank;
        old_rank   = rank_reg[touch_idx];
        valid_next = valid_reg;
        for (int j = 0; j < FRAME_COUNT; j++) begin
            rank_next[j] = rank_reg[j];
            if (touch.en) begin
                if (FIDX_W'(j) == touch_idx) begin
                    rank_next[j] = RANK_W'(1);
                    if (touch.fill) begin
                        valid_next[j] = 1'b1;
                    end
                end else if ((rank_reg[j] != '0) &&
                             ((old_rank == '0) || (rank_reg[j] < old_rank))) begin
                    rank_next[j] = rank_reg[j] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int j = 0; j < FRAME_COUNT; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            for (int j = 0; j < FRAME_COUNT; j++) begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    assign valid_vec = valid_reg;
    assign rd_rank   = rank_reg[rd_idx];

endmodule

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page replacement over fully associative frames
// Each input word is one page reference; each output word reports hit or
// fault, the frame used, any evicted page and saturating totals.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one page number per word. The m_ channel returns
//   exactly one result word per accepted reference, in order.
//   frames_in_use is written through cfg_we/cfg_wdata while the block is
//   idle; 0 acts as one frame and values above FRAME_COUNT act as
//   FRAME_COUNT. Frames beyond the active set keep their contents.
//   The scan reads the page RAM one frame per cycle through a single
//   compare unit, over the active frames only. The update step then loads
//   the result word into the output register once that register is free.
//   s_tready is high only while the sequencer is idle. A finished result
//   sits in the output register, so the next reference is accepted and
//   scanned while the receiver stalls; its result waits in the update step
//   until the output register is free.
//   Reset clears all valid bits, ranks, totals and the output valid flag, and
//   sets frames_in_use to 8. The page RAM needs no clearing since an entry
//   is only compared while its valid bit is set.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lpr_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: frames_in_use.
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Input stream. tdata: [15:0] page_number.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Output stream.
    // tdata: [2:0] frame_index, [18:3] evicted_page, [34:19] fault_total,
    //        [50:35] hit_total, [55:51] zero.
    // tuser: [0] hit, [1] evicted_valid.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int FIDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int RANK_W = $clog2(FRAME_COUNT + 1);
    localparam int CNT_W  = $clog2(FRAME_COUNT + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    // Sequencer state.
    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 cmp_vld_reg;
    logic [FIDX_W-1:0]    cmp_idx_reg;
    logic [PAGE_BITS-1:0] key_reg;
    logic [CFG_W-1:0]     frames_in_use_reg;

    // Totals and output register.
    logic [TOTAL_W-1:0]   fault_reg;
    logic [TOTAL_W-1:0]   fault_next;
    logic [TOTAL_W-1:0]   hits_reg;
    logic [TOTAL_W-1:0]   hits_next;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    logic                 s_accept;
    logic                 issue;
    logic                 update_go;
    logic [CNT_W-1:0]     n_calc;
    logic [PAGE_BITS-1:0] ram_rdata;
    logic [FRAME_COUNT-1:0] valid_vec;
    logic [RANK_W-1:0]    rd_rank;
    scan_flags_t          flags;
    logic [FIDX_W-1:0]    hit_idx;
    logic [FIDX_W-1:0]    empty_idx;
    logic [FIDX_W-1:0]    vic_idx;
    logic [PAGE_BITS-1:0] vic_page;
    logic [FIDX_W-1:0]    frame_sel;
    logic                 ev_valid;
    logic [31:0]          frame_ext;
    logic [31:0]          vic_ext;
    logic [EVICT_W-1:0]   ev_page;
    touch_ctl_t           touch;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg != n_reg);
    assign update_go = (state_reg == ST_UPDATE) && (!m_valid_reg || m_tready);

    // Clamp the frames_in_use register to between one and the implemented frames.
    always_comb begin
        if (frames_in_use_reg == '0) begin
            n_calc = CNT_W'(1);
        end else if (32'(frames_in_use_reg) > FRAME_COUNT) begin
            n_calc = CNT_W'(FRAME_COUNT);
        end else begin
            n_calc = CNT_W'(frames_in_use_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The last frame is compared in the cycle where no read issues.
                if (!issue) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (update_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            n_reg             <= CNT_W'(1);
            cmp_vld_reg       <= 1'b0;
            frames_in_use_reg <= CFG_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                frames_in_use_reg <= cfg_wdata;
            end
            if (s_accept) begin
                cnt_reg     <= '0;
                n_reg       <= n_calc;
                cmp_vld_reg <= 1'b0;
            end else begin
                cmp_vld_reg <= issue;
                if (issue) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg <= PAGE_BITS'(s_tdata[PAGE_IN_W-1:0]);
        end
        if (issue) begin
            cmp_idx_reg <= cnt_reg[FIDX_W-1:0];
        end
    end

    // Page store, read one frame per scan cycle, written on a fill.
    lpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAME_COUNT)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (update_go && !flags.hit),
        .waddr (frame_sel),
        .wdata (key_reg),
        .raddr (cnt_reg[FIDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lpr_scan_unit #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_accept),
        .cmp_en      (cmp_vld_reg),
        .cmp_idx     (cmp_idx_reg),
        .key         (key_reg),
        .frame_page  (ram_rdata),
        .frame_valid (valid_vec[cmp_idx_reg]),
        .frame_rank  (rd_rank),
        .flags       (flags),
        .hit_idx     (hit_idx),
        .empty_idx   (empty_idx),
        .vic_idx     (vic_idx),
        .vic_page    (vic_page)
    );

    assign touch.en   = update_go;
    assign touch.fill = !flags.hit;

    lpr_rank_table #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_ranks (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .touch     (touch),
        .touch_idx (frame_sel),
        .rd_idx    (cmp_idx_reg),
        .valid_vec (valid_vec),
        .rd_rank   (rd_rank)
    );

    // A hit wins, then the lowest empty frame, then the oldest frame.
    always_comb begin
        if (flags.hit) begin
            frame_sel = hit_idx;
        end else if (flags.empty_found) begin
            frame_sel = empty_idx;
        end else begin
            frame_sel = vic_idx;
        end
    end

    assign ev_valid  = !flags.hit && !flags.empty_found;
    assign frame_ext = 32'(frame_sel);
    assign vic_ext   = 32'(vic_page);
    assign ev_page   = ev_valid ? vic_ext[EVICT_W-1:0] : '0;

    always_comb begin
        fault_next = fault_reg;
        hits_next  = hits_reg;
        if (flags.hit) begin
            if (hits_reg != '1) begin
                hits_next = hits_reg + TOTAL_W'(1);
            end
        end else begin
            if (fault_reg != '1) begin
                fault_next = fault_reg + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg   <= '0;
            hits_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (update_go) begin
                fault_reg   <= fault_next;
                hits_reg    <= hits_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (update_go) begin
            m_data_reg <= {5'd0, hits_next, fault_next, ev_page,
                           frame_ext[FRAME_OUT_W-1:0]};
            m_user_reg <= {ev_valid, flags.hit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A reference is never accepted in two consecutive cycles.
    a_single_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a reference is in progress");

    // A result is either a hit or may carry an eviction, never both.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit result reports an evicted page");

    // The scan never reads past the active frames.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= n_reg))
        else $error("scan counter beyond the active frames");

    // The output register is only reloaded once its word has been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");

endmodule

// ===== tb/sv/tb_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_lru_page_replacement: self-checking bench for the LRU page replacement
// Streams page references into the block and checks every result word
// against a built-in LRU predictor, across several frame counts.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
    import lpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_N      = FRAME_COUNT_DEF;
    localparam int LIMIT_CYCLES = 3_000_000;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE       = 16;
    localparam int REPORT_MAX   = 10;

    // One result word, unpacked into its fields.
    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   ev_valid;
        logic [EVICT_W-1:0]     ev_page;
        logic [TOTAL_W-1:0]     faults;
        logic [TOTAL_W-1:0]     hits;
    } page_result_t;

    // Tracks the frame table the way the block should and holds the results
    // that are still owed by the block, oldest first.
    class lru_frame_tracker;
        logic [CFG_W-1:0]     frames_cfg;
        bit                   frame_used[FRAME_N];
        logic [PAGE_IN_W-1:0] frame_page[FRAME_N];
        // Recency rank: 0 = never touched, 1 = most recent, larger = older.
        int unsigned          recency[FRAME_N];
        logic [TOTAL_W-1:0]   faults;
        logic [TOTAL_W-1:0]   hits;
        page_result_t         pending_results[$];
        int unsigned          mismatches;
        int unsigned          checked;

        function new();
            frames_cfg  = CFG_RESET;
            faults      = '0;
            hits        = '0;
            mismatches  = 0;
            checked     = 0;
            foreach (frame_used[k]) begin
                frame_used[k] = 1'b0;
                frame_page[k] = '0;
                recency[k]    = 0;
            end
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            frames_cfg = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_reference(logic [PAGE_IN_W-1:0] page);
            int           n;
            int           sel;
            int unsigned  oldest;
            int unsigned  old_rank;
            bit           found;
            bit           is_hit;
            page_result_t r;

            n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAME_N) ? FRAME_N : int'(frames_cfg);
            found  = 1'b0;
            is_hit = 1'b0;
            sel    = 0;
            r      = '0;

            // A hit goes to the lowest active frame holding the page.
            for (int k = 0; k < n && !found; k++) begin
                if (frame_used[k] && frame_page[k] == page) begin
                    sel    = k;
                    found  = 1'b1;
                    is_hit = 1'b1;
                end
            end
            // Otherwise the lowest empty active frame is filled.
            for (int k = 0; k < n && !found; k++) begin
                if (!frame_used[k]) begin
                    sel   = k;
                    found = 1'b1;
                end
            end
            // Otherwise the oldest active frame is replaced.
            if (!found) begin
                oldest = recency[0];
                sel    = 0;
                for (int k = 1; k < n; k++) begin
                    if (recency[k] > oldest) begin
                        oldest = recency[k];
                        sel    = k;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = frame_page[sel];
            end

            if (is_hit) begin
                if (hits != '1) hits++;
            end else begin
                if (faults != '1) faults++;
                frame_used[sel] = 1'b1;
                frame_page[sel] = page;
            end

            // Move the touched frame to the front of the recency order.
            old_rank = recency[sel];
            for (int k = 0; k < FRAME_N; k++) begin
                if (k != sel && recency[k] != 0 && (old_rank == 0 || recency[k] < old_rank))
                    recency[k]++;
            end
            recency[sel] = 1;

            r.hit    = is_hit;
            r.frame  = sel[FRAME_OUT_W-1:0];
            r.faults = faults;
            r.hits   = hits;
            pending_results.push_back(r);
        endfunction

        function void check_result(page_result_t got);
            page_result_t want;

            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result word %0d arrived with nothing expected", checked);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result word %0d mismatch", checked);
                    $display("  expected hit=%0b frame=%0d evict=%0b page=%h faults=%0d hits=%0d",
                             want.hit, want.frame, want.ev_valid, want.ev_page,
                             want.faults, want.hits);
                    $display("  actual   hit=%0b frame=%0d evict=%0b page=%h faults=%0d hits=%0d",
                             got.hit, got.frame, got.ev_valid, got.ev_page,
                             got.faults, got.hits);
                end
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // When set, neither side of the bench inserts idle cycles.
    bit                   steady    = 1'b0;
    int unsigned          cycle_count = 0;
    lru_frame_tracker     tracker;

    lru_page_replacement dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver stalls about a third of the time unless the bench is in
    // a steady stretch. A fresh decision each cycle spreads the stalls over
    // every step of the block's work.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // Every result word accepted at this edge is handed to the tracker.
    // Outputs are read right after the edge, so they still hold the values
    // that the handshake saw.
    always @(posedge aclk) begin
        page_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit      = m_tuser[0];
            got.ev_valid = m_tuser[1];
            got.frame    = m_tdata[2:0];
            got.ev_page  = m_tdata[18:3];
            got.faults   = m_tdata[34:19];
            got.hits     = m_tdata[50:35];
            tracker.check_result(got);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Writes frames_in_use. Called only while the block is idle, so the
    // tracker can take the new value at once.
    task automatic write_frames(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.set_frames(value);
    endtask

    // Offers one page reference and returns at the edge where the word is
    // taken. tvalid stays high on return, so back-to-back words need only
    // one assignment per edge; a gap or the end of a phase lowers it.
    task automatic send_page(input logic [PAGE_IN_W-1:0] page);
        if (!steady && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        do @(posedge aclk); while (!s_tready);
        tracker.note_reference(page);
    endtask

    // Stops the source and waits until every owed result has come back,
    // then lets the block settle so that it is idle for a register write.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        logic [PAGE_IN_W-1:0] pool[12];
        logic [PAGE_IN_W-1:0] page;
        int                   pool_n;

        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Eight frames: the extreme page numbers, a hit, the
        // remaining frames filled, a replacement of the oldest frame, a last hit.
        write_frames(4'd8);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h1111);
        send_page(16'h2222);
        send_page(16'h4444);
        send_page(16'h8888);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h7777);
        send_page(16'h0000);
        drain();

        // Shrink to two frames. Pages held in the upper frames are out of
        // reach, so the first two replace within frames 0 and 1; the third hits.
        write_frames(4'd2);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h5555);
        drain();

        // Grow again with a value above the frame count, which acts as the
        // full set. The same page now sits in two frames and the lower one
        // must take the hit; a new page then evicts the oldest of all eight.
        write_frames(4'd15);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h3333);
        drain();

        // Zero acts as a single frame.
        write_frames(4'd0);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'hABCD);
        drain();

        // Random part. Each phase picks a frame count and a working set of two
        // to twelve pages, so hits, fills and replacements all occur; a quarter
        // of the references are fresh random pages. One phase runs without any
        // idling.
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0)
                write_frames(4'd8);
            else if (ph == 9)
                write_frames(4'd1);
            else
                write_frames(CFG_W'($urandom_range(0, 15)));
            steady = (ph == 4);
            pool_n = $urandom_range(2, 12);
            foreach (pool[k])
                pool[k] = PAGE_IN_W'($urandom_range(0, 16'hFFFF));
            for (int i = 0; i < 175; i++) begin
                if ($urandom_range(0, 99) < 75)
                    page = pool[$urandom_range(0, pool_n - 1)];
                else
                    page = PAGE_IN_W'($urandom_range(0, 16'hFFFF));
                // Let the working set drift now and then.
                if ($urandom_range(0, 99) < 5)
                    pool[$urandom_range(0, pool_n - 1)] = PAGE_IN_W'($urandom_range(0, 16'hFFFF));
                send_page(page);
            end
            drain();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
